FILE: src/diagonal_gradient_bayer_dither_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the diagonal gradient dither block
// Shorthand for clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIAGONAL_GRADIENT_BAYER_DITHER_MACROS_SVH
`define DIAGONAL_GRADIENT_BAYER_DITHER_MACROS_SVH

// Same-cycle implication
`define DGBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DGBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dgbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbd_pkg
// Types, constants and tables shared by the gradient dither block.
// ----------------------------------------------------------------------------
package dgbd_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DITHER_SIZE = 4;

    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;
    localparam int WEIGHT_W   = 9;                 // weight spans 0..256
    localparam int DIVIDEND_W = COORD_W + 8;       // pos * 256
    localparam int DIVISOR_W  = 12;                // dim - 1, at most 4095
    localparam int DIV_STAGES = WEIGHT_W;          // one quotient bit per stage
    localparam int BAYER_W    = 4;

    localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
    localparam logic [CHAN_W-1:0] START_RED_RST    = 8'd128;
    localparam logic [CHAN_W-1:0] START_GREEN_RST  = 8'd0;
    localparam logic [CHAN_W-1:0] START_BLUE_RST   = 8'd192;
    localparam logic [CHAN_W-1:0] END_RED_RST      = 8'd255;
    localparam logic [CHAN_W-1:0] END_GREEN_RST    = 8'd128;
    localparam logic [CHAN_W-1:0] END_BLUE_RST     = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_START_RED    = 3'd2,
        CFG_START_GREEN  = 3'd3,
        CFG_START_BLUE   = 3'd4,
        CFG_END_RED      = 3'd5,
        CFG_END_GREEN    = 3'd6,
        CFG_END_BLUE     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [15:0] color565;
        logic        inside_res;
    } pixel_out_t;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    // 4x4 ordered dither matrix, indexed by row then column
    function automatic logic [BAYER_W-1:0] bayer_value(input logic [1:0] row,
                                                       input logic [1:0] col);
        logic [BAYER_W-1:0] val;
        case ({row, col})
            4'h0: val = 4'd0;
            4'h1: val = 4'd8;
            4'h2: val = 4'd2;
            4'h3: val = 4'd10;
            4'h4: val = 4'd12;
            4'h5: val = 4'd4;
            4'h6: val = 4'd14;
            4'h7: val = 4'd6;
            4'h8: val = 4'd3;
            4'h9: val = 4'd11;
            4'hA: val = 4'd1;
            4'hB: val = 4'd9;
            4'hC: val = 4'd15;
            4'hD: val = 4'd7;
            4'hE: val = 4'd13;
            default: val = 4'd5;
        endcase
        return val;
    endfunction

endpackage

FILE: src/dgbd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbd_div
// Pipelined restoring divider producing the 9-bit position weight,
// one quotient bit per register stage.
// ----------------------------------------------------------------------------
module dgbd_div
    import dgbd_pkg::*;
(
    input  logic                clk,
    input  logic                advance,
    input  div_req_t            req,
    output logic [WEIGHT_W-1:0] quotient
);

    logic [DIVIDEND_W-1:0] rem_reg [DIV_STAGES];
    logic [WEIGHT_W-1:0]   quo_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int SHIFT = DIV_STAGES - 1 - s;

        logic [DIVIDEND_W-1:0] rem_in;
        logic [WEIGHT_W-1:0]   quo_in;
        logic [DIVIDEND_W:0]   trial;
        logic [DIVIDEND_W-1:0] rem_next;
        logic [WEIGHT_W-1:0]   quo_next;

        if (s == 0) begin : g_first
            assign rem_in = req.dividend;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        // subtract divisor aligned to this quotient bit; the top bit is the borrow
        assign trial = {1'b0, rem_in}
                     - ({{(DIVIDEND_W + 1 - DIVISOR_W){1'b0}}, req.divisor} << SHIFT);

        always_comb
        begin
            quo_next        = quo_in;
            quo_next[SHIFT] = ~trial[DIVIDEND_W];
            rem_next        = trial[DIVIDEND_W] ? rem_in : trial[DIVIDEND_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

FILE: src/diagonal_gradient_bayer_dither.sv
`timescale 1ns / 1ps
// Pipeline: an input transfer loads the first of twelve register stages, and the result
// shows on out_valid/out_data from the last of them.
// Throughput: one pixel per cycle when not stalled; the nine-stage divider sets depth.
// A stall on the output freezes every stage at once; nothing is dropped.
// Reset: clears all valid bits and loads the registers with their default colors/frame.
`include "diagonal_gradient_bayer_dither_macros.svh"
// ----------------------------------------------------------------------------
// diagonal_gradient_bayer_dither
// Diagonal two-color gradient pixel generator with 4x4 ordered dither and
// RGB565 packing. Stages: input register, 9 divider stages for the x/y
// weights, interpolation stage, then average/dither/clamp into the output
// register.
// ----------------------------------------------------------------------------
module diagonal_gradient_bayer_dither
    import dgbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel coordinate channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pixel_in_t             in_data,
    // color result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output pixel_out_t            out_data,
    // register write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [CHAN_W-1:0] start_red_reg;
    logic [CHAN_W-1:0] start_green_reg;
    logic [CHAN_W-1:0] start_blue_reg;
    logic [CHAN_W-1:0] end_red_reg;
    logic [CHAN_W-1:0] end_green_reg;
    logic [CHAN_W-1:0] end_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            start_red_reg    <= START_RED_RST;
            start_green_reg  <= START_GREEN_RST;
            start_blue_reg   <= START_BLUE_RST;
            end_red_reg      <= END_RED_RST;
            end_green_reg    <= END_GREEN_RST;
            end_blue_reg     <= END_BLUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_START_RED:    start_red_reg    <= cfg_data[CHAN_W-1:0];
                CFG_START_GREEN:  start_green_reg  <= cfg_data[CHAN_W-1:0];
                CFG_START_BLUE:   start_blue_reg   <= cfg_data[CHAN_W-1:0];
                CFG_END_RED:      end_red_reg      <= cfg_data[CHAN_W-1:0];
                CFG_END_GREEN:    end_green_reg    <= cfg_data[CHAN_W-1:0];
                CFG_END_BLUE:     end_blue_reg     <= cfg_data[CHAN_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame geometry from registers; user keeps them static while busy, unenforced
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]     width_eff;
    logic [DIM_W-1:0]     height_eff;
    logic [DIM_W-1:0]     width_m1;
    logic [DIM_W-1:0]     height_m1;
    logic [DIVISOR_W-1:0] divisor_x;
    logic [DIVISOR_W-1:0] divisor_y;

    // saturate each dimension at the largest supported frame
    assign width_eff  = (frame_width_reg  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width_reg;
    assign height_eff = (frame_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height_reg;
    assign width_m1   = width_eff  - DIM_W'(1);
    assign height_m1  = height_eff - DIM_W'(1);

    // A one-pixel axis only ever sees position 0, so dividing by one gives
    // the required zero weight without a separate bypass.
    assign divisor_x = (width_eff  <= DIM_W'(1)) ? DIVISOR_W'(1) : width_m1[DIVISOR_W-1:0];
    assign divisor_y = (height_eff <= DIM_W'(1)) ? DIVISOR_W'(1) : height_m1[DIVISOR_W-1:0];

    // ------------------------------------------------------------------
    // Global advance: the whole pipe moves unless a finished result is held
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance  = ~(out_valid_reg & out_stall);
    assign in_stall = ~advance;

    // ------------------------------------------------------------------
    // Stage A: register the coordinate, frame test and dither entry
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic               a_inside_reg;
    logic [BAYER_W-1:0] a_bayer_reg;
    logic [COORD_W-1:0] a_x_reg;
    logic [COORD_W-1:0] a_y_reg;
    logic               a_inside_next;
    logic [BAYER_W-1:0] a_bayer_next;

    assign a_inside_next = ({1'b0, in_data.pixel_x} < width_eff)
                         & ({1'b0, in_data.pixel_y} < height_eff);
    assign a_bayer_next  = bayer_value(in_data.pixel_y[1:0], in_data.pixel_x[1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_inside_reg <= a_inside_next;
            a_bayer_reg  <= a_bayer_next;
            a_x_reg      <= in_data.pixel_x;
            a_y_reg      <= in_data.pixel_y;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: weight t = pos * 256 / (dim - 1) for both axes
    // ------------------------------------------------------------------
    div_req_t            req_x;
    div_req_t            req_y;
    logic [WEIGHT_W-1:0] weight_x;
    logic [WEIGHT_W-1:0] weight_y;

    assign req_x.dividend = {a_x_reg, 8'h00};
    assign req_x.divisor  = divisor_x;
    assign req_y.dividend = {a_y_reg, 8'h00};
    assign req_y.divisor  = divisor_y;

    dgbd_div u_div_x
    (
        .clk      (clk),
        .advance  (advance),
        .req      (req_x),
        .quotient (weight_x)
    );

    dgbd_div u_div_y
    (
        .clk      (clk),
        .advance  (advance),
        .req      (req_y),
        .quotient (weight_y)
    );

    // valid and sideband travel alongside the divider stages
    logic               dv_valid_reg  [DIV_STAGES];
    logic               dv_inside_reg [DIV_STAGES];
    logic [BAYER_W-1:0] dv_bayer_reg  [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            dv_valid_reg[0] <= a_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_inside_reg[0] <= a_inside_reg;
            dv_bayer_reg[0]  <= a_bayer_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_inside_reg[i] <= dv_inside_reg[i-1];
                dv_bayer_reg[i]  <= dv_bayer_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Interpolation stage: per channel, per axis ((256-t)*s + t*e) >> 8
    // ------------------------------------------------------------------
    function automatic logic [CHAN_W-1:0] lerp8(input logic [WEIGHT_W-1:0] t,
                                                input logic [CHAN_W-1:0]   s,
                                                input logic [CHAN_W-1:0]   e);
        logic [WEIGHT_W-1:0]          inv;
        logic [WEIGHT_W+CHAN_W-1:0]   p_start;
        logic [WEIGHT_W+CHAN_W-1:0]   p_end;
        logic [WEIGHT_W+CHAN_W:0]     total;
        inv     = WEIGHT_W'(256) - t;
        p_start = inv * s;
        p_end   = t * e;
        total   = {1'b0, p_start} + {1'b0, p_end};
        return total[CHAN_W+7:8];
    endfunction

    logic [CHAN_W-1:0]  start_col [3];
    logic [CHAN_W-1:0]  end_col   [3];
    logic               l_valid_reg;
    logic               l_inside_reg;
    logic [BAYER_W-1:0] l_bayer_reg;
    logic [CHAN_W-1:0]  l_ramp_x_reg [3];
    logic [CHAN_W-1:0]  l_ramp_y_reg [3];

    // channel order: red, green, blue
    assign start_col[0] = start_red_reg;
    assign start_col[1] = start_green_reg;
    assign start_col[2] = start_blue_reg;
    assign end_col[0]   = end_red_reg;
    assign end_col[1]   = end_green_reg;
    assign end_col[2]   = end_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            l_valid_reg <= dv_valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            l_inside_reg <= dv_inside_reg[DIV_STAGES-1];
            l_bayer_reg  <= dv_bayer_reg[DIV_STAGES-1];
            for (int c = 0; c < 3; c++)
            begin
                l_ramp_x_reg[c] <= lerp8(weight_x, start_col[c], end_col[c]);
                l_ramp_y_reg[c] <= lerp8(weight_y, start_col[c], end_col[c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: average the ramps, add dither minus 8, clamp, pack
    // ------------------------------------------------------------------
    function automatic logic [CHAN_W-1:0] dither_chan(input logic [CHAN_W-1:0]  a,
                                                      input logic [CHAN_W-1:0]  b,
                                                      input logic [BAYER_W-1:0] bay);
        logic [CHAN_W:0]          total;
        logic signed [CHAN_W+1:0] val;
        logic [CHAN_W-1:0]        res;
        total = {1'b0, a} + {1'b0, b};
        val   = $signed({2'b00, total[CHAN_W:1]})
              + $signed({{(CHAN_W + 2 - BAYER_W){1'b0}}, bay})
              - (CHAN_W + 2)'(8);
        if (val < 0)
        begin
            res = '0;
        end
        else if (val > (CHAN_W + 2)'(255))
        begin
            res = '1;
        end
        else
        begin
            res = val[CHAN_W-1:0];
        end
        return res;
    endfunction

    logic [CHAN_W-1:0] red_pix;
    logic [CHAN_W-1:0] green_pix;
    logic [CHAN_W-1:0] blue_pix;
    pixel_out_t        out_data_next;
    pixel_out_t        out_data_reg;

    assign red_pix   = dither_chan(l_ramp_x_reg[0], l_ramp_y_reg[0], l_bayer_reg);
    assign green_pix = dither_chan(l_ramp_x_reg[1], l_ramp_y_reg[1], l_bayer_reg);
    assign blue_pix  = dither_chan(l_ramp_x_reg[2], l_ramp_y_reg[2], l_bayer_reg);

    always_comb
    begin
        out_data_next.inside_res = l_inside_reg;
        // outside the frame the color is forced to black
        if (l_inside_reg)
        begin
            out_data_next.color565 = {red_pix[7:3], green_pix[7:2], blue_pix[7:3]};
        end
        else
        begin
            out_data_next.color565 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DGBD_ASSERT_NOW(a_weight_range,
        dv_valid_reg[DIV_STAGES-1] && dv_inside_reg[DIV_STAGES-1],
        weight_x <= WEIGHT_W'(256) && weight_y <= WEIGHT_W'(256),
        "position weight above 256 for an in-frame pixel")
    `DGBD_ASSERT_NOW(a_outside_black,
        out_valid_reg && !out_data_reg.inside_res,
        out_data_reg.color565 == 16'h0000,
        "out-of-frame pixel carries a nonzero color")
    `DGBD_ASSERT_NEXT(a_hold_on_stall,
        !advance,
        $stable(a_valid_reg) && $stable(l_valid_reg) && $stable(dv_valid_reg[0]),
        "pipeline valid bits moved during a stall")
    `DGBD_ASSERT_NEXT(a_stage_advance,
        advance && a_valid_reg,
        dv_valid_reg[0],
        "item lost between input stage and divider")

endmodule

FILE: test/diagonal_gradient_bayer_dither_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient dither pixel generator testbench
// Feeds pixel coordinates through the valid/stall channel, predicts each
// RGB565 color and frame flag from the current register set, and checks
// every result in order. Runs a directed pass over the frame corners, the
// dimension edge cases and the clamp limits, then randomized frames with
// random colors under three source/sink idling mixes.
// ----------------------------------------------------------------------------
module diagonal_gradient_bayer_dither_tb;
    import dgbd_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int QUIET_LIMIT   = 4000;   // cycles with no transfer on either side
    localparam int SETTLE_CYCLES = 24;     // twice the pipeline depth
    localparam int RANDOM_FRAMES = 9;
    localparam int PIXELS_PER_FRAME = 88;

    // 4x4 ordered dither matrix, entry row*4+col in nibble row*4+col
    localparam logic [63:0] DITHER_NIBBLES = 64'h5D7F_91B3_6E4C_A280;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    pixel_in_t             in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    pixel_out_t            out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copy kept by the testbench, already masked to register width
    logic [DIM_W-1:0] regs_now [8];

    pixel_in_t  coord_queue[$];       // coordinates waiting for the driver
    pixel_out_t expected_pixels[$];   // predicted colors, oldest first

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int failures      = 0;
    int quiet_cycles  = 0;

    diagonal_gradient_bayer_dither DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Color prediction
    // ------------------------------------------------------------------

    // Dimension as the block sees it: saturate at the largest frame
    function automatic int unsigned frame_dim(logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // Position weight 0..256 along one axis; a one-pixel axis stays at start
    function automatic int unsigned axis_weight(int unsigned pos, int unsigned dim);
        if (dim <= 1)
            return 0;
        return (pos * 256) / (dim - 1);
    endfunction

    function automatic int unsigned ramp(int unsigned t, int unsigned s, int unsigned e);
        return (((256 - t) * s + t * e) >> 8) & 32'hFF;
    endfunction

    // Average the two axis ramps, add the dither offset, clamp to a byte
    function automatic logic [CHAN_W-1:0] shade(int unsigned tx, int unsigned ty,
                                                 logic [DIM_W-1:0] s, logic [DIM_W-1:0] e,
                                                 int offset);
        int level;
        level = int'((ramp(tx, s, e) + ramp(ty, s, e)) >> 1) + offset;
        if (level < 0)
            level = 0;
        if (level > 255)
            level = 255;
        return CHAN_W'(level);
    endfunction

    function automatic pixel_out_t gradient_pixel(pixel_in_t p);
        pixel_out_t       res;
        int unsigned      w;
        int unsigned      h;
        int unsigned      tx;
        int unsigned      ty;
        int               offset;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        w = frame_dim(regs_now[CFG_FRAME_WIDTH]);
        h = frame_dim(regs_now[CFG_FRAME_HEIGHT]);
        res = '0;
        if (p.pixel_x < w && p.pixel_y < h)
        begin
            tx = axis_weight(p.pixel_x, w);
            ty = axis_weight(p.pixel_y, h);
            offset = int'(DITHER_NIBBLES[{p.pixel_y[1:0], p.pixel_x[1:0], 2'b00} +: 4]) - 8;
            r = shade(tx, ty, regs_now[CFG_START_RED],   regs_now[CFG_END_RED],   offset);
            g = shade(tx, ty, regs_now[CFG_START_GREEN], regs_now[CFG_END_GREEN], offset);
            b = shade(tx, ty, regs_now[CFG_START_BLUE],  regs_now[CFG_END_BLUE],  offset);
            res.color565   = {r[7:3], g[7:2], b[7:3]};
            res.inside_res = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued coordinates, hold each until it transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            // a held coordinate that moves now gets its prediction recorded
            if (in_valid)
                expected_pixels.push_back(gradient_pixel(in_data));
            if (coord_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= coord_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        pixel_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: result with none pending: color565 %h inside_res %b",
                             $time, out_data.color565, out_data.inside_res);
                    failures++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data.color565 !== want.color565)
                    begin
                        $display("%0t: color565 expected %h, got %h",
                                 $time, want.color565, out_data.color565);
                        failures++;
                    end
                    if (out_data.inside_res !== want.inside_res)
                    begin
                        $display("%0t: inside_res expected %b, got %b",
                                 $time, want.inside_res, out_data.inside_res);
                        failures++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idling(int src_pct, int sink_pct);
        @(posedge clk);
        src_idle_pct  <= src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    // Write all eight registers back to back, then drop the write enable.
    // Only call with the pipeline empty.
    task automatic program_regs(int unsigned w, int unsigned h,
                                int unsigned sr, int unsigned sg,
                                int unsigned sb, int unsigned er,
                                int unsigned eg, int unsigned eb);
        logic [DIM_W-1:0] vals [8];
        vals[CFG_FRAME_WIDTH]  = DIM_W'(w);
        vals[CFG_FRAME_HEIGHT] = DIM_W'(h);
        vals[CFG_START_RED]    = DIM_W'(sr);
        vals[CFG_START_GREEN]  = DIM_W'(sg);
        vals[CFG_START_BLUE]   = DIM_W'(sb);
        vals[CFG_END_RED]      = DIM_W'(er);
        vals[CFG_END_GREEN]    = DIM_W'(eg);
        vals[CFG_END_BLUE]     = DIM_W'(eb);
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i];
            // color registers keep only their low byte
            if (cfg_index_t'(i) == CFG_FRAME_WIDTH || cfg_index_t'(i) == CFG_FRAME_HEIGHT)
                regs_now[i] = vals[i];
            else
                regs_now[i] = {5'b0, vals[i][7:0]};
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(int unsigned x, int unsigned y);
        pixel_in_t p;
        p.pixel_x = COORD_W'(x);
        p.pixel_y = COORD_W'(y);
        coord_queue.push_back(p);
    endtask

    // Mostly coordinates inside the current frame, the rest anywhere
    task automatic push_random(int count);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        w = frame_dim(regs_now[CFG_FRAME_WIDTH]);
        h = frame_dim(regs_now[CFG_FRAME_HEIGHT]);
        repeat (count)
        begin
            if (w != 0 && $urandom_range(0, 99) < 85)
                x = $urandom_range(0, w - 1);
            else
                x = $urandom_range(0, 4095);
            if (h != 0 && $urandom_range(0, 99) < 85)
                y = $urandom_range(0, h - 1);
            else
                y = $urandom_range(0, 4095);
            push_pixel(x, y);
        end
    endtask

    // Wait on settled values until every coordinate has moved and every
    // prediction has been matched
    task automatic drain();
        do
            @(negedge clk);
        while (coord_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
    endtask

    // Small frames most of the time so the ramps get fully walked
    function automatic logic [DIM_W-1:0] random_dim();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return DIM_W'($urandom_range(2, 64));
        if (pick < 90)
            return DIM_W'($urandom_range(2, 8191));
        case ($urandom_range(0, 3))
            0:       return DIM_W'(0);
            1:       return DIM_W'(1);
            2:       return DIM_W'(MAX_DIM);
            default: return DIM_W'(8191);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        regs_now[CFG_FRAME_WIDTH]  = FRAME_WIDTH_RST;
        regs_now[CFG_FRAME_HEIGHT] = FRAME_HEIGHT_RST;
        regs_now[CFG_START_RED]    = {5'b0, START_RED_RST};
        regs_now[CFG_START_GREEN]  = {5'b0, START_GREEN_RST};
        regs_now[CFG_START_BLUE]   = {5'b0, START_BLUE_RST};
        regs_now[CFG_END_RED]      = {5'b0, END_RED_RST};
        regs_now[CFG_END_GREEN]    = {5'b0, END_GREEN_RST};
        regs_now[CFG_END_BLUE]     = {5'b0, END_BLUE_RST};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(11, 58);

        // Reset colors and 640x480: corners, both edges just outside,
        // far corner of the coordinate space
        push_pixel(0, 0);
        push_pixel(639, 479);
        push_pixel(640, 0);
        push_pixel(0, 480);
        push_pixel(4095, 4095);
        push_pixel(3, 3);
        push_pixel(1, 2);
        drain();

        // Largest frame; red pinned at 0 and green at 255 so the dither
        // offset clamps at both ends
        program_regs(MAX_DIM, MAX_DIM, 0, 255, 0, 0, 255, 255);
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(4095, 0);
        push_pixel(0, 4095);
        push_pixel(2730, 1365);
        drain();

        // Smallest regular frame with opposite extreme colors
        program_regs(2, 2, 255, 0, 255, 0, 255, 0);
        push_pixel(0, 0);
        push_pixel(1, 1);
        push_pixel(1, 0);
        push_pixel(2, 1);
        drain();

        // Oversized dimensions saturate; color data carries high bits
        // that the registers must drop
        program_regs(8191, 5000, 13'h1E12, 13'h1F80, 13'h10FF, 13'h0A55, 13'h1C3C, 13'h1101);
        push_pixel(4095, 4095);
        push_pixel(2048, 4095);
        drain();

        // One-pixel-wide frame: x weight stays at the start color
        program_regs(1, MAX_DIM, 40, 90, 200, 250, 10, 60);
        push_pixel(0, 100);
        push_pixel(0, 4095);
        push_pixel(1, 0);
        drain();

        // Zero-width frame: everything falls outside
        program_regs(0, 7, 1, 2, 3, 4, 5, 6);
        push_pixel(0, 0);
        push_pixel(5, 3);
        drain();

        // Random frames and colors: the first third with a busy sink, the
        // next with a busy source, the last with no idling at all; the
        // first frame spans the whole coordinate range
        for (int frame = 0; frame < RANDOM_FRAMES; frame++)
        begin
            case ((frame * 3) / RANDOM_FRAMES)
                0:       set_idling(11, 58);
                1:       set_idling(58, 11);
                default: set_idling(0, 0);
            endcase
            if (frame == 0)
                program_regs(MAX_DIM, MAX_DIM,
                             $urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 8191), $urandom_range(0, 8191));
            else
                program_regs(random_dim(), random_dim(),
                             $urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 8191), $urandom_range(0, 8191));
            push_random(PIXELS_PER_FRAME);
            drain();
        end

        // Let any stray result show up before judging
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d predicted results never arrived", $time,
                     expected_pixels.size());
            failures++;
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/dgbd_pkg.sv
src/dgbd_div.sv
src/diagonal_gradient_bayer_dither.sv
test/diagonal_gradient_bayer_dither_tb.sv
